>>> design/ipv4rf_pkg.sv
// Package for the IPv4 receive filter.
// Holds the verdict codes, header constants and the captured-header struct.
// No dependencies.
package ipv4rf_pkg;

    // Byte counter saturation limit
    localparam logic [15:0] MAX_PACKET_BYTES = 16'd65535;
    // Byte index at which the captured fields stop updating
    localparam logic [15:0] LAST_TAKEN_INDEX = 16'hFFFF;
    localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
    localparam logic [15:0] CHECKSUM_GOOD    = 16'hFFFF;
    localparam logic [31:0] BROADCAST_ADDR   = 32'hFFFF_FFFF;
    localparam logic [7:0]  PROTO_TCP        = 8'd6;
    localparam logic [7:0]  PROTO_ICMP       = 8'd1;
    localparam logic [3:0]  IHL_MASK         = 4'hF;

    // Header byte positions
    localparam logic [15:0] IDX_VER_IHL   = 16'd0;
    localparam logic [15:0] IDX_TLEN_HI   = 16'd2;
    localparam logic [15:0] IDX_TLEN_LO   = 16'd3;
    localparam logic [15:0] IDX_PROTOCOL  = 16'd9;
    localparam logic [15:0] IDX_SRC_FIRST = 16'd12;
    localparam logic [15:0] IDX_SRC_LAST  = 16'd15;
    localparam logic [15:0] IDX_DST_FIRST = 16'd16;
    localparam logic [15:0] IDX_DST_LAST  = 16'd19;

    // Verdict codes
    localparam logic [2:0] VERDICT_TCP       = 3'd0;
    localparam logic [2:0] VERDICT_ICMP      = 3'd1;
    localparam logic [2:0] VERDICT_OTHER     = 3'd2;
    localparam logic [2:0] VERDICT_SHORT     = 3'd3;
    localparam logic [2:0] VERDICT_BAD_IHL   = 3'd4;
    localparam logic [2:0] VERDICT_BAD_TOTAL = 3'd5;
    localparam logic [2:0] VERDICT_BAD_SUM   = 3'd6;
    localparam logic [2:0] VERDICT_NOT_OURS  = 3'd7;

    // Header state as it stands after the current word
    typedef struct packed {
        logic [15:0] byte_count;
        logic [15:0] checksum;
        logic [5:0]  header_length;
        logic [15:0] total_length;
        logic [7:0]  protocol;
        logic [31:0] source_address;
        logic [31:0] destination_address;
    } hdr_view_t;

endpackage

>>> design/ipv4rf_parser.sv
// Per-packet header capture and running one's-complement checksum.
// Depends on ipv4rf_pkg.
module ipv4rf_parser
    import ipv4rf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,        // one packet word is consumed this cycle
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output hdr_view_t  hdr_next     // state including the current word
);

    logic [15:0] count_reg;
    logic [15:0] sum_reg;
    logic [7:0]  high_reg;
    logic [5:0]  hlen_reg;
    logic [15:0] tlen_reg;
    logic [7:0]  proto_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;

    logic [15:0] count_next;
    logic [15:0] sum_next;
    logic [7:0]  high_next;
    logic [5:0]  hlen_next;
    logic [15:0] tlen_next;
    logic [7:0]  proto_next;
    logic [31:0] src_next;
    logic [31:0] dst_next;

    logic        take;
    logic [16:0] sum_wide;

    // Field capture and checksum accumulation for the current word
    always_comb
    begin
        take       = (count_reg != LAST_TAKEN_INDEX);
        hlen_next  = hlen_reg;
        tlen_next  = tlen_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        high_next  = high_reg;
        sum_next   = sum_reg;
        sum_wide   = {1'b0, sum_reg} + {1'b0, high_reg, data_byte};

        if (take)
        begin
            if (count_reg == IDX_VER_IHL)
            begin
                hlen_next = {data_byte[3:0] & IHL_MASK, 2'b00};
            end
            else if (count_reg == IDX_TLEN_HI)
            begin
                tlen_next = {data_byte, tlen_reg[7:0]};
            end
            else if (count_reg == IDX_TLEN_LO)
            begin
                tlen_next = {tlen_reg[15:8], data_byte};
            end
            else if (count_reg == IDX_PROTOCOL)
            begin
                proto_next = data_byte;
            end
            else if (count_reg >= IDX_SRC_FIRST && count_reg <= IDX_SRC_LAST)
            begin
                src_next = {src_reg[23:0], data_byte};
            end
            else if (count_reg >= IDX_DST_FIRST && count_reg <= IDX_DST_LAST)
            begin
                dst_next = {dst_reg[23:0], data_byte};
            end

            // Even index holds the high byte; odd index closes a header word.
            if (!count_reg[0])
            begin
                high_next = data_byte;
            end
            else if (count_reg < {10'd0, hlen_reg})
            begin
                sum_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
            end
        end

        count_next = (count_reg < MAX_PACKET_BYTES) ? count_reg + 16'd1 : count_reg;
    end

    assign hdr_next = '{
        byte_count:          count_next,
        checksum:            sum_next,
        header_length:       hlen_next,
        total_length:        tlen_next,
        protocol:            proto_next,
        source_address:      src_next,
        destination_address: dst_next
    };

    // State registers, including the header-length used as the checksum limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            high_reg  <= '0;
            hlen_reg  <= '0;
            tlen_reg  <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                high_reg  <= '0;
                hlen_reg  <= '0;
                tlen_reg  <= '0;
                proto_reg <= '0;
                src_reg   <= '0;
                dst_reg   <= '0;
            end
            else
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                high_reg  <= high_next;
                hlen_reg  <= hlen_next;
                tlen_reg  <= tlen_next;
                proto_reg <= proto_next;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
            end
        end
    end

endmodule

>>> design/ipv4_receive_filter_top.sv
// IPv4 receive filter: top level with input stage, verdict logic and result register.
// Depends on ipv4rf_pkg and ipv4rf_parser.
//
// The filter takes one packet byte per cycle on the s_ stream and gives one
// result word per packet on the m_ stream; m_tvalid rises as the packet's last
// byte leaves the input register. Throughput is one byte per clock, set by the
// combinational header update and verdict stage between the input register and
// the result register. Bytes keep flowing while a result waits to be taken; the
// input stalls only while the next packet's last byte sits in the input register
// and the previous result is still pending. local_address may be written on the
// cfg channel at any time the filter is idle; it is accepted every cycle.
module ipv4_receive_filter_top
    import ipv4rf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: local IPv4 address
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // Packet byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // last_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [7:0] protocol, [39:8] source_address,
                                    // [45:40] payload_offset, [61:46] payload_length
    output logic [2:0]  m_tuser     // [2:0] verdict
);

    logic [31:0] local_addr_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    logic        out_valid_reg;
    logic [2:0]  verdict_reg;
    logic [7:0]  protocol_reg;
    logic [31:0] source_reg;
    logic [5:0]  offset_reg;
    logic [15:0] plen_reg;

    logic        advance;
    hdr_view_t   hdr;
    logic [15:0] hlen_wide;
    logic [2:0]  verdict_next;
    logic [15:0] plen_next;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_addr_reg <= '0;
        end
        else if (cfg_valid)
        begin
            local_addr_reg <= cfg_data;
        end
    end

    // A valid word advances unless it is last and a pending result is not taken
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ipv4rf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .hdr_next  (hdr)
    );

    // Packet checks in priority order
    assign hlen_wide = {10'd0, hdr.header_length};

    always_comb
    begin
        plen_next = '0;
        if (hdr.byte_count < MIN_HEADER_BYTES)
        begin
            verdict_next = VERDICT_SHORT;
        end
        else if (hlen_wide < MIN_HEADER_BYTES || hlen_wide > hdr.byte_count)
        begin
            verdict_next = VERDICT_BAD_IHL;
        end
        else if (hdr.total_length > hdr.byte_count || hdr.total_length < hlen_wide)
        begin
            verdict_next = VERDICT_BAD_TOTAL;
        end
        else if (hdr.checksum != CHECKSUM_GOOD)
        begin
            verdict_next = VERDICT_BAD_SUM;
        end
        else if (hdr.destination_address != local_addr_reg &&
                 hdr.destination_address != BROADCAST_ADDR)
        begin
            verdict_next = VERDICT_NOT_OURS;
        end
        else
        begin
            plen_next = hdr.total_length - hlen_wide;
            if (hdr.protocol == PROTO_TCP)
            begin
                verdict_next = VERDICT_TCP;
            end
            else if (hdr.protocol == PROTO_ICMP)
            begin
                verdict_next = VERDICT_ICMP;
            end
            else
            begin
                verdict_next = VERDICT_OTHER;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            verdict_reg  <= verdict_next;
            protocol_reg <= hdr.protocol;
            source_reg   <= hdr.source_address;
            offset_reg   <= hdr.header_length;
            plen_reg     <= plen_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = verdict_reg;
    assign m_tdata  = {2'b00, plen_reg, offset_reg, source_reg, protocol_reg};

    // A failed check never reports a payload length.
    a_reject_no_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && verdict_reg >= VERDICT_SHORT |-> plen_reg == 16'd0)
        else $error("rejected packet carries a payload length");

    // A delivered packet has a legal header length.
    a_deliver_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && verdict_reg < VERDICT_SHORT |-> offset_reg >= 6'd20)
        else $error("delivered packet with short header");

    // Loading a verdict always presents it next cycle.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> out_valid_reg)
        else $error("verdict lost");

    // A stalled word in the input register is kept until it is processed.
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
                                     && $stable(in_last_reg))
        else $error("stalled input word overwritten");

    // A new last word cannot replace an untaken result.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !(advance && in_last_reg))
        else $error("pending result overwritten");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the IPv4 receive filter, driven over its byte and result streams.
// A directed packet table and random packets are checked against an in-bench header predictor.
// Depends on ipv4rf_pkg and ipv4_receive_filter_top.
module tb_top;
    import ipv4rf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_BYTES    = 170;
    localparam int PHASE_PACKETS  = 6;
    // Marks a packet whose expected verdict comes only from the predictor
    localparam int CALC           = -1;

    // One result word as the filter reports it
    typedef struct packed {
        logic [2:0]  verdict;
        logic [7:0]  protocol;
        logic [31:0] source;
        logic [5:0]  offset;
        logic [15:0] payload_bytes;
    } verdict_word_t;

    // Recipe for one packet, plus an optional address write before it
    typedef struct {
        logic        set_addr;
        logic [31:0] addr;
        logic [3:0]  ihl;
        logic        tot_exact;
        logic [15:0] total;
        logic [7:0]  proto;
        logic [31:0] dst;
        int          body_len;
        int          pad;
        int          cut;
        logic        bad_sum;
        logic        noise;
        int          typed;
    } frame_plan_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;

    // Predictor copy of the filter state and its address register
    logic [15:0] rx_count = '0;
    logic [16:0] rx_sum = '0;
    logic [7:0]  rx_hi = '0;
    logic [5:0]  rx_hlen = '0;
    logic [15:0] rx_total = '0;
    logic [7:0]  rx_proto = '0;
    logic [31:0] rx_src = '0;
    logic [31:0] rx_dst = '0;
    logic [31:0] own_addr = '0;

    verdict_word_t awaited_verdicts[$];
    int            typed_verdicts[$];
    logic [7:0]    frame_q[$];
    frame_plan_t   plan_rows[$];

    int          idle_pct = 0;
    int          stall_pct = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          packets_sent = 0;
    int          bytes_sent = 0;
    int          addr_writes = 0;
    int          quiet_cycles = 0;
    logic [7:0]  verdicts_seen = '0;

    ipv4_receive_filter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver side: stall the result stream at the current rate.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Advance the header predictor by one accepted byte word; at the last byte
    // queue the verdict word it expects.
    function automatic void absorb_byte(input logic [7:0] b, input logic last);
        logic [15:0]   idx;
        verdict_word_t w;
        int            typed;
        idx = rx_count;
        if (idx != 16'hFFFF)
        begin
            if (idx == IDX_VER_IHL)
                rx_hlen = {b[3:0], 2'b00};
            else if (idx == IDX_TLEN_HI)
                rx_total[15:8] = b;
            else if (idx == IDX_TLEN_LO)
                rx_total[7:0] = b;
            else if (idx == IDX_PROTOCOL)
                rx_proto = b;
            else if (idx >= IDX_SRC_FIRST && idx <= IDX_SRC_LAST)
                rx_src = {rx_src[23:0], b};
            else if (idx >= IDX_DST_FIRST && idx <= IDX_DST_LAST)
                rx_dst = {rx_dst[23:0], b};
            // Even bytes are held as the high half of a header word.
            if (!idx[0])
                rx_hi = b;
            else if (idx < rx_hlen)
            begin
                rx_sum = rx_sum + {1'b0, rx_hi, b};
                if (rx_sum[16])
                    rx_sum = {1'b0, rx_sum[15:0]} + 17'd1;
            end
        end
        if (rx_count != 16'hFFFF)
            rx_count = rx_count + 16'd1;
        if (!last)
            return;

        // Checks in priority order; only delivery carries a payload length.
        w.protocol      = rx_proto;
        w.source        = rx_src;
        w.offset        = rx_hlen;
        w.payload_bytes = '0;
        if (rx_count < MIN_HEADER_BYTES)
            w.verdict = VERDICT_SHORT;
        else if (rx_hlen < MIN_HEADER_BYTES || rx_hlen > rx_count)
            w.verdict = VERDICT_BAD_IHL;
        else if (rx_total > rx_count || rx_total < rx_hlen)
            w.verdict = VERDICT_BAD_TOTAL;
        else if (rx_sum[15:0] != CHECKSUM_GOOD)
            w.verdict = VERDICT_BAD_SUM;
        else if (rx_dst != own_addr && rx_dst != BROADCAST_ADDR)
            w.verdict = VERDICT_NOT_OURS;
        else
        begin
            w.payload_bytes = rx_total - rx_hlen;
            if (rx_proto == PROTO_TCP)
                w.verdict = VERDICT_TCP;
            else if (rx_proto == PROTO_ICMP)
                w.verdict = VERDICT_ICMP;
            else
                w.verdict = VERDICT_OTHER;
        end

        // A verdict typed into the directed table takes precedence.
        typed = (typed_verdicts.size() != 0) ? typed_verdicts.pop_front() : CALC;
        if (typed >= 0)
        begin
            w.verdict = typed[2:0];
            if (w.verdict >= VERDICT_SHORT)
                w.payload_bytes = '0;
        end
        awaited_verdicts.push_back(w);

        rx_count = '0;
        rx_sum   = '0;
        rx_hi    = '0;
        rx_hlen  = '0;
        rx_total = '0;
        rx_proto = '0;
        rx_src   = '0;
        rx_dst   = '0;
    endfunction

    // Monitor: track address writes and input words, check result words, and
    // end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        verdict_word_t got;
        verdict_word_t want;
        if (rst_n)
        begin
            quiet_cycles = quiet_cycles + 1;
            if (cfg_valid && cfg_ready)
            begin
                own_addr = cfg_data;
                quiet_cycles = 0;
            end
            if (s_tvalid && s_tready)
            begin
                absorb_byte(s_tdata, s_tlast);
                quiet_cycles = 0;
            end
            if (m_tvalid && m_tready)
            begin
                quiet_cycles = 0;
                results_seen = results_seen + 1;
                got.verdict       = m_tuser;
                got.protocol      = m_tdata[7:0];
                got.source        = m_tdata[39:8];
                got.offset        = m_tdata[45:40];
                got.payload_bytes = m_tdata[61:46];
                verdicts_seen[got.verdict] = 1'b1;
                if (awaited_verdicts.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result word with none expected: verdict %0d", $realtime,
                                 got.verdict);
                end
                else
                begin
                    want = awaited_verdicts.pop_front();
                    if (got !== want)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("%0t: expected verdict %0d proto %02h src %08h off %0d len %0d",
                                     $realtime, want.verdict, want.protocol, want.source,
                                     want.offset, want.payload_bytes);
                            $display("%0t:      got verdict %0d proto %02h src %08h off %0d len %0d",
                                     $realtime, got.verdict, got.protocol, got.source,
                                     got.offset, got.payload_bytes);
                        end
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Drive one byte word, idling at random beforehand, and wait for acceptance.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every expected result has come, then let
    // the pipeline settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_local_addr(input logic [31:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        addr_writes = addr_writes + 1;
    endtask

    // Lay out a packet from its recipe, with a correct header checksum unless
    // the recipe asks for a corrupt one or for plain noise.
    task automatic build_frame(input frame_plan_t p);
        int          hlen;
        int          hdr;
        logic [15:0] tot;
        logic [31:0] src;
        logic [16:0] acc;
        frame_q.delete();
        if (p.noise)
        begin
            repeat (p.cut) frame_q.push_back(8'($urandom));
            return;
        end
        hlen = p.ihl * 4;
        hdr  = (hlen < 20) ? 20 : hlen;
        tot  = p.tot_exact ? 16'(hdr + p.body_len) : p.total;
        src  = $urandom;
        repeat (hdr) frame_q.push_back(8'($urandom));
        frame_q[0]  = {4'($urandom), p.ihl};
        frame_q[2]  = tot[15:8];
        frame_q[3]  = tot[7:0];
        frame_q[9]  = p.proto;
        frame_q[10] = 8'h00;
        frame_q[11] = 8'h00;
        for (int i = 12; i < 16; i++)
            frame_q[i] = src[8*(15-i) +: 8];
        for (int i = 16; i < 20; i++)
            frame_q[i] = p.dst[8*(19-i) +: 8];
        acc = '0;
        for (int i = 0; i + 1 < hlen; i += 2)
        begin
            acc = acc + {1'b0, frame_q[i], frame_q[i+1]};
            if (acc[16])
                acc = {1'b0, acc[15:0]} + 17'd1;
        end
        frame_q[10] = ~acc[15:8];
        frame_q[11] = ~acc[7:0];
        if (p.bad_sum)
            frame_q[10] = frame_q[10] ^ 8'($urandom_range(255, 1));
        repeat (p.body_len + p.pad) frame_q.push_back(8'($urandom));
        if (p.cut > 0)
            while (frame_q.size() > p.cut)
                void'(frame_q.pop_back());
    endtask

    task automatic send_frame(input int typed);
        int n;
        n = frame_q.size();
        typed_verdicts.push_back(typed);
        for (int i = 0; i < n; i++)
            send_byte(frame_q[i], i == n - 1);
        packets_sent = packets_sent + 1;
        bytes_sent   = bytes_sent + n;
    endtask

    function automatic frame_plan_t frame_row(input logic set_addr, input logic [31:0] addr,
                                              input logic [3:0] ihl, input logic tot_exact,
                                              input logic [15:0] total, input logic [7:0] proto,
                                              input logic [31:0] dst, input int body_len,
                                              input int pad, input int cut, input logic bad_sum,
                                              input int typed);
        frame_plan_t p;
        p.set_addr  = set_addr;
        p.addr      = addr;
        p.ihl       = ihl;
        p.tot_exact = tot_exact;
        p.total     = total;
        p.proto     = proto;
        p.dst       = dst;
        p.body_len  = body_len;
        p.pad       = pad;
        p.cut       = cut;
        p.bad_sum   = bad_sum;
        p.noise     = 1'b0;
        p.typed     = typed;
        return p;
    endfunction

    // Mostly well-formed packets with random content; the rest are broken on
    // one check each, or plain noise.
    function automatic frame_plan_t random_plan();
        frame_plan_t p;
        int          pick;
        int          hlen;
        pick = $urandom_range(99);
        p = frame_row(1'b0, '0, 4'($urandom_range(6, 5)), 1'b1, '0, 8'($urandom), own_addr,
                      $urandom_range(12), 0, 0, 1'b0, CALC);
        if ($urandom_range(3) == 0)
            p.ihl = 4'($urandom_range(15, 5));
        case ($urandom_range(3))
            0: p.proto = PROTO_TCP;
            1: p.proto = PROTO_ICMP;
            default: p.proto = 8'($urandom);
        endcase
        case ($urandom_range(4))
            3: p.dst = BROADCAST_ADDR;
            4: p.dst = $urandom;
            default: p.dst = own_addr;
        endcase
        if ($urandom_range(3) == 0)
            p.pad = $urandom_range(4, 1);
        hlen = p.ihl * 4;
        if (pick < 70)
            p.bad_sum = 1'b0;
        else if (pick < 76)
            p.bad_sum = 1'b1;
        else if (pick < 80)
            p.ihl = 4'($urandom_range(4));
        else if (pick < 84)
        begin
            // Header claims more bytes than the packet holds.
            p.ihl = 4'($urandom_range(15, 6));
            p.cut = $urandom_range(p.ihl * 4 - 1, 20);
        end
        else if (pick < 88)
        begin
            p.tot_exact = 1'b0;
            p.total = 16'($urandom_range(65535, hlen + p.body_len + p.pad + 1));
        end
        else if (pick < 91)
        begin
            p.tot_exact = 1'b0;
            p.total = 16'($urandom_range(hlen - 1, 0));
        end
        else if (pick < 95)
            p.cut = $urandom_range(19, 1);
        else
        begin
            p.noise = 1'b1;
            p.cut = $urandom_range(40, 1);
        end
        return p;
    endfunction

    initial
    begin
        frame_plan_t p;
        int          phase_start;
        int          phase_packets;
        logic [31:0] phase_addr;

        // Directed packets. Columns: address write, address, ihl, exact total,
        // total, protocol, destination, payload, trailer, cut, corrupt sum, verdict.
        // Right after reset the address is zero, so destination zero is ours.
        plan_rows.push_back(frame_row(0, 32'h0, 5, 1, 0, PROTO_TCP, 32'h0,
                                      0, 0, 0, 0, VERDICT_TCP));
        // Longest header, all-ones address.
        plan_rows.push_back(frame_row(1, 32'hFFFF_FFFF, 15, 1, 0, PROTO_ICMP, 32'hFFFF_FFFF,
                                      4, 0, 0, 0, VERDICT_ICMP));
        plan_rows.push_back(frame_row(1, 32'hC0A8_0001, 5, 1, 0, 8'hFF, 32'hC0A8_0001,
                                      3, 0, 0, 0, VERDICT_OTHER));
        plan_rows.push_back(frame_row(0, 32'h0, 5, 1, 0, 8'h00, BROADCAST_ADDR,
                                      1, 0, 0, 0, VERDICT_OTHER));
        plan_rows.push_back(frame_row(0, 32'h0, 5, 1, 0, PROTO_TCP, 32'h0A00_0001,
                                      2, 0, 0, 0, VERDICT_NOT_OURS));
        plan_rows.push_back(frame_row(0, 32'h0, 5, 1, 0, PROTO_TCP, 32'hC0A8_0001,
                                      2, 0, 0, 1, VERDICT_BAD_SUM));
        plan_rows.push_back(frame_row(0, 32'h0, 0, 1, 0, PROTO_TCP, 32'hC0A8_0001,
                                      2, 0, 0, 0, VERDICT_BAD_IHL));
        plan_rows.push_back(frame_row(0, 32'h0, 4, 1, 0, PROTO_TCP, 32'hC0A8_0001,
                                      2, 0, 0, 0, VERDICT_BAD_IHL));
        // Header length larger than the whole packet.
        plan_rows.push_back(frame_row(0, 32'h0, 15, 1, 0, PROTO_TCP, 32'hC0A8_0001,
                                      0, 0, 40, 0, VERDICT_BAD_IHL));
        plan_rows.push_back(frame_row(0, 32'h0, 5, 0, 16'hFFFF, PROTO_TCP, 32'hC0A8_0001,
                                      4, 0, 0, 0, VERDICT_BAD_TOTAL));
        plan_rows.push_back(frame_row(0, 32'h0, 5, 0, 16'd19, PROTO_TCP, 32'hC0A8_0001,
                                      4, 0, 0, 0, VERDICT_BAD_TOTAL));
        plan_rows.push_back(frame_row(0, 32'h0, 6, 0, 16'd0, PROTO_TCP, 32'hC0A8_0001,
                                      4, 0, 0, 0, VERDICT_BAD_TOTAL));
        // Trailer bytes past the total length are allowed.
        plan_rows.push_back(frame_row(0, 32'h0, 5, 1, 0, PROTO_TCP, 32'hC0A8_0001,
                                      6, 6, 0, 0, VERDICT_TCP));
        // Short packets, ending before or inside the captured fields.
        plan_rows.push_back(frame_row(0, 32'h0, 5, 1, 0, PROTO_TCP, 32'hC0A8_0001,
                                      0, 0, 1, 0, VERDICT_SHORT));
        plan_rows.push_back(frame_row(0, 32'h0, 5, 1, 0, PROTO_ICMP, 32'hC0A8_0001,
                                      0, 0, 10, 0, VERDICT_SHORT));
        plan_rows.push_back(frame_row(0, 32'h0, 5, 1, 0, PROTO_TCP, 32'hC0A8_0001,
                                      0, 0, 19, 0, VERDICT_SHORT));
        plan_rows.push_back(frame_row(0, 32'h0, 7, 1, 0, 8'd17, 32'hC0A8_0001,
                                      5, 0, 0, 0, CALC));
        plan_rows.push_back(frame_row(0, 32'h0, 15, 1, 0, PROTO_TCP, 32'hC0A8_0001,
                                      0, 0, 0, 0, CALC));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling.
        foreach (plan_rows[i])
        begin
            if (plan_rows[i].set_addr)
                write_local_addr(plan_rows[i].addr);
            build_frame(plan_rows[i]);
            send_frame(plan_rows[i].typed);
        end

        // Random part in four idle/stall mixes, each with its own address.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: phase_addr = $urandom;
                1: phase_addr = 32'h0;
                2: phase_addr = $urandom;
                default: phase_addr = 32'hFFFF_FFFF;
            endcase
            write_local_addr(phase_addr);
            idle_pct  = (ph == 1) ? 49 : (ph == 3) ? 19 : 0;
            stall_pct = (ph == 2) ? 49 : (ph == 3) ? 19 : 0;
            phase_start = bytes_sent;
            phase_packets = 0;
            while (bytes_sent - phase_start < PHASE_BYTES || phase_packets < PHASE_PACKETS)
            begin
                p = random_plan();
                build_frame(p);
                send_frame(p.typed);
                phase_packets = phase_packets + 1;
                if ($urandom_range(7) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d packets (%0d bytes) under %0d address writes; %0d results checked.",
                 packets_sent, bytes_sent, addr_writes, results_seen);
        $display("Verdicts observed (bit per code): %b, mismatches: %0d.",
                 verdicts_seen, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
design/ipv4rf_pkg.sv
design/ipv4rf_parser.sv
design/ipv4_receive_filter_top.sv
sim/tb_top.sv
